// ===== sv/block_terminal_write_order_parser_unit_assert.svh =====
`ifndef BLOCK_TERMINAL_WRITE_ORDER_PARSER_UNIT_ASSERT_SVH
`define BLOCK_TERMINAL_WRITE_ORDER_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define BTWOP_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("btwop check failed");

// next-cycle implication, quiet while reset is held
`define BTWOP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("btwop check failed");

// next-cycle implication that also covers the reset cycles
`define BTWOP_ASSERT_RST(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("btwop check failed");

`endif

// ===== sv/btwop_pkg.sv =====
`default_nettype none

package btwop_pkg;

  localparam int MAX_CELLS = 4096;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int POS_W     = 12;
  localparam int CHAR_W    = 7;
  localparam int ROWS_W    = 7;
  localparam int COLS_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int OPCNT_W   = 9;
  localparam int PROD_W    = ROWS_W + COLS_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;
  localparam logic [ROWS_W-1:0]    ROWS_RST = 7'd24;
  localparam logic [COLS_W-1:0]    COLS_RST = 8'd80;

  localparam logic [7:0] CMD_EW    = 8'hF5;
  localparam logic [7:0] CMD_EWA   = 8'h7E;
  localparam logic [7:0] CMD_W     = 8'hF1;
  localparam logic [7:0] ORD_SBA   = 8'h11;
  localparam logic [7:0] ORD_SF    = 8'h1D;
  localparam logic [7:0] ORD_SFE   = 8'h29;
  localparam logic [7:0] ORD_RA    = 8'h3C;
  localparam logic [7:0] ORD_EUA   = 8'h12;
  localparam logic [7:0] ORD_SA    = 8'h28;
  localparam logic [7:0] ORD_MF    = 8'h2C;
  localparam logic [7:0] ORD_IC    = 8'h13;
  localparam logic [7:0] ORD_PT    = 8'h05;
  localparam logic [7:0] ATTR_FLD  = 8'hC0;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WCC, PH_DATA, PH_ADDR_HI, PH_ADDR_LO, PH_RA_FILL, PH_SF,
    PH_SFE_CNT, PH_SFE_TYPE, PH_SFE_VAL_FLD, PH_SFE_VAL_OTH, PH_SKIP, PH_MF_CNT
  } phase_t;

  typedef enum logic [1:0] {KIND_SBA, KIND_RA, KIND_EUA} kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_FIC, ST_RA,
    ST_EUA_BR, ST_EUA_BE, ST_EUA_FR, ST_EUA_FE, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_DONE, ACT_CLEAR, ACT_READ, ACT_FIC, ACT_RA, ACT_EUA
  } act_t;

  typedef struct packed {
    logic prot;
    logic fs;
  } mark_t;

  typedef struct packed {
    logic             op;
    logic [7:0]       data_byte;
    logic             first_of_record;
    logic             last_of_record;
    logic [POS_W-1:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              cell_is_field_start;
    logic              cell_protected;
    logic [POS_W-1:0]  cursor_position;
  } out_item_t;

  function automatic logic [CNT_W-1:0] cell_count(input logic [ROWS_W-1:0] rows,
                                                 input logic [COLS_W-1:0] cols);
    logic [ROWS_W-1:0] r;
    logic [COLS_W-1:0] c;
    logic [PROD_W-1:0] p;
    r = (rows == '0) ? ROWS_W'(1) : rows;
    c = (cols == '0) ? COLS_W'(1) : cols;
    p = PROD_W'(r) * PROD_W'(c);
    if (p > PROD_W'(MAX_CELLS)) p = PROD_W'(MAX_CELLS);
    return CNT_W'(p);
  endfunction

  function automatic logic [CHAR_W-1:0] ebcdic_to_ascii(input logic [7:0] c);
    logic [7:0] a;
    a = 8'h20;
    if (c >= 8'hF0 && c <= 8'hF9)      a = 8'h30 + (c - 8'hF0);
    else if (c >= 8'hC1 && c <= 8'hC9) a = 8'h41 + (c - 8'hC1);
    else if (c >= 8'hD1 && c <= 8'hD9) a = 8'h4A + (c - 8'hD1);
    else if (c >= 8'hE2 && c <= 8'hE9) a = 8'h53 + (c - 8'hE2);
    else if (c >= 8'h81 && c <= 8'h89) a = 8'h61 + (c - 8'h81);
    else if (c >= 8'h91 && c <= 8'h99) a = 8'h6A + (c - 8'h91);
    else if (c >= 8'hA2 && c <= 8'hA9) a = 8'h73 + (c - 8'hA2);
    else begin
      case (c)
        8'h4B:   a = 8'h2E;
        8'h6B:   a = 8'h2C;
        8'h5A:   a = 8'h21;
        8'h6E:   a = 8'h3E;
        8'h4C:   a = 8'h3C;
        8'h5B:   a = 8'h24;
        8'h7B:   a = 8'h23;
        8'h7E:   a = 8'h3D;
        8'h60:   a = 8'h2D;
        8'h61:   a = 8'h2F;
        8'h6C:   a = 8'h25;
        8'h7C:   a = 8'h40;
        8'h4D:   a = 8'h28;
        8'h5D:   a = 8'h29;
        8'h50:   a = 8'h26;
        8'h7A:   a = 8'h3A;
        8'h5E:   a = 8'h3B;
        8'h6D:   a = 8'h5F;
        8'h7D:   a = 8'h27;
        8'h7F:   a = 8'h22;
        8'h4E:   a = 8'h2B;
        8'h5C:   a = 8'h2A;
        8'h4F:   a = 8'h7C;
        8'h6F:   a = 8'h3F;
        default: a = 8'h20;
      endcase
    end
    return a[CHAR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/block_terminal_write_order_parser_unit.sv =====
// block-mode terminal write-record parser
// in channel: in_valid / in_stall / in_data. a request is either one record byte
//   (op 0, with first/last record marks) or a read of one screen cell (op 1)
// out channel: out_valid / out_stall / out_data, exactly one result per request,
//   in request order; record bytes return zero cell fields and the new cursor
// cfg port: cfg_we / cfg_index / cfg_data writes screen rows (0) or columns (1)
// one request is in flight at a time; in_stall is high while it is worked on
// plain characters and most orders finish in the accept cycle, a cell read
//   does one memory read, RA writes the fill character one cell at a time,
//   EUA walks back cell by cell to a field start and then forward to its stop,
//   PT and end-of-record placement scan the mark memory across the n screen
//   cells, Erase/Write sweeps every cell of both memories
// throughput: up to one request per cycle for characters and short orders while
//   no result stalls; walks are paced by the single-port character and mark memories
// the result register lets a request be accepted while the previous result is
//   still stalled; a finished result then waits in a holding state
// reset: the memories are swept to spaces and zero marks,
//   in_stall stays high meanwhile, geometry returns to 24 x 80
`default_nettype none

module block_terminal_write_order_parser_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire btwop_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output btwop_pkg::out_item_t                     out_data,
  input  wire logic                                cfg_we,
  input  wire logic [btwop_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [btwop_pkg::CFG_W-1:0]         cfg_data
);
  import btwop_pkg::*;

  // screen storage: one character memory and one field-mark memory
  logic [CHAR_W-1:0] char_mem [MAX_CELLS];
  mark_t             mark_mem [MAX_CELLS];

  // control state
  state_t             st_r, st_nxt;
  phase_t             phase_r, phase_nxt;
  kind_t              kind_r, kind_nxt;
  logic [ADDR_W-1:0]  cursor_r, cursor_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [ROWS_W-1:0]  rows_r, rows_nxt;
  logic [COLS_W-1:0]  cols_r, cols_nxt;
  logic [OPCNT_W-1:0] cnt_r, cnt_nxt;
  logic [5:0]         paddr_r, paddr_nxt;
  logic               pprot_r, pprot_nxt;
  logic               anyf_r, anyf_nxt;
  logic [ADDR_W-1:0]  stop_r, stop_nxt;
  logic               ficaft_r, ficaft_nxt;
  logic               inf_r, inf_nxt;
  logic               eprot_r, eprot_nxt;
  logic [ADDR_W-1:0]  back_r, back_nxt;
  logic [ADDR_W-1:0]  iss_r, iss_nxt;
  logic [ADDR_W-1:0]  di_r, di_nxt;
  logic               dv_r, dv_nxt;
  logic               pufs_r, pufs_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               clr_item_r, clr_item_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload state
  logic [CHAR_W-1:0]  fill_r, fill_nxt;
  logic [CHAR_W-1:0]  res_char_r, res_char_nxt;
  logic               res_fs_r, res_fs_nxt;
  logic               res_prot_r, res_prot_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic [CHAR_W-1:0]  rd_char_r;
  mark_t              rd_mark_r;

  // memory port controls
  logic               cw_en, mw_en;
  logic [ADDR_W-1:0]  cw_addr, mw_addr, rd_addr;
  logic [CHAR_W-1:0]  cw_data;
  mark_t              mw_data;

  // decode helpers
  act_t               act;
  logic               in_acc, out_free, active, is_erase;
  logic               do_sf, sf_prot, do_put;
  logic [7:0]         b;
  logic [CHAR_W-1:0]  ebc;
  logic [POS_W-1:0]   a12;
  logic [ADDR_W-1:0]  a_dec, ra_stop, rd_cl, nm1, cur_adv;
  logic               walk_end, fic_hit, fic_end, clr_last, fic_go;
  logic [ROWS_W-1:0]  rows_new;
  logic [COLS_W-1:0]  cols_new;
  logic [CNT_W-1:0]   cells_new;
  logic [OPCNT_W-1:0] cnt_dec;

  assign in_stall  = (st_r != ST_IDLE) || !rst_n;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign b        = in_data.data_byte;
  assign ebc      = ebcdic_to_ascii(b);
  assign active   = in_data.first_of_record || (phase_r != PH_IDLE);
  assign is_erase = (b == CMD_EW) || (b == CMD_EWA);
  assign nm1      = ADDR_W'(n_r - CNT_W'(1));
  assign cur_adv  = ((CNT_W'(cursor_r) + CNT_W'(1)) == n_r) ? '0
                  : cursor_r + ADDR_W'(1);
  assign cnt_dec  = cnt_r - OPCNT_W'(1);

  // address operand: two 6-bit halves, clamped to the last cell
  assign a12   = {paddr_r, b[5:0]};
  assign a_dec = ((POS_W+1)'(a12) >= (POS_W+1)'(n_r)) ? nm1 : ADDR_W'(a12);
  assign rd_cl = ((POS_W+1)'(in_data.read_address) >= (POS_W+1)'(n_r)) ? nm1
               : ADDR_W'(in_data.read_address);
  // geometry may have shrunk since the RA address arrived
  assign ra_stop = (CNT_W'(stop_r) >= n_r) ? nm1 : stop_r;

  // walks stop at the stop cell or when the cursor wraps
  assign walk_end = (cur_adv == stop_r) || (cur_adv == '0);
  assign fic_go   = ficaft_r && anyf_r;

  // first-input-cell scan: previous cell unprotected field start, this one not
  assign fic_hit  = dv_r && pufs_r && !rd_mark_r.fs;
  assign fic_end  = dv_r && (fic_hit || (CNT_W'(di_r) == n_r - CNT_W'(1)));
  assign clr_last = (clr_cnt_r == ADDR_W'(MAX_CELLS - 1));

  assign rows_new  = (cfg_index == REG_ROWS) ? cfg_data[ROWS_W-1:0] : rows_r;
  assign cols_new  = (cfg_index == REG_COLS) ? cfg_data[COLS_W-1:0] : cols_r;
  assign cells_new = cell_count(rows_new, cols_new);

  // memories: one write per memory and one shared read address per cycle
  always_ff @(posedge clk) begin
    if (cw_en) char_mem[cw_addr] <= cw_data;
    if (mw_en) mark_mem[mw_addr] <= mw_data;
    rd_char_r <= char_mem[rd_addr];
    rd_mark_r <= mark_mem[rd_addr];
  end

  // datapath and memory controls
  always_comb begin
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    cursor_nxt    = cursor_r;
    n_nxt         = n_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    cnt_nxt       = cnt_r;
    paddr_nxt     = paddr_r;
    pprot_nxt     = pprot_r;
    anyf_nxt      = anyf_r;
    stop_nxt      = stop_r;
    ficaft_nxt    = ficaft_r;
    inf_nxt       = inf_r;
    eprot_nxt     = eprot_r;
    back_nxt      = back_r;
    iss_nxt       = iss_r;
    di_nxt        = di_r;
    dv_nxt        = dv_r;
    pufs_nxt      = pufs_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_item_nxt  = clr_item_r;
    fill_nxt      = fill_r;
    res_char_nxt  = res_char_r;
    res_fs_nxt    = res_fs_r;
    res_prot_nxt  = res_prot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    act           = ACT_NONE;
    do_sf         = 1'b0;
    sf_prot       = 1'b0;
    do_put        = 1'b0;
    cw_en         = 1'b0;
    cw_addr       = cursor_r;
    cw_data       = CHAR_SPACE;
    mw_en         = 1'b0;
    mw_addr       = cursor_r;
    mw_data       = '0;
    rd_addr       = cursor_r;

    case (st_r)
      ST_CLEAR: begin
        cw_en       = 1'b1;
        cw_addr     = clr_cnt_r;
        mw_en       = 1'b1;
        mw_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end

      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.op) begin
            rd_addr = rd_cl;
            act     = ACT_READ;
          end else begin
            act          = ACT_DONE;
            res_char_nxt = '0;
            res_fs_nxt   = 1'b0;
            res_prot_nxt = 1'b0;
            if (in_data.first_of_record) begin
              if (is_erase) begin
                cursor_nxt   = '0;
                anyf_nxt     = 1'b0;
                clr_cnt_nxt  = '0;
                clr_item_nxt = 1'b1;
                act          = ACT_CLEAR;
              end
              phase_nxt = (is_erase || (b == CMD_W)) ? PH_WCC : PH_DATA;
              cnt_nxt   = '0;
            end else if (active) begin
              case (phase_r)
                PH_WCC: phase_nxt = PH_DATA;
                PH_ADDR_HI: begin
                  paddr_nxt = b[5:0];
                  phase_nxt = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                  phase_nxt = PH_DATA;
                  case (kind_r)
                    KIND_SBA: cursor_nxt = a_dec;
                    KIND_RA: begin
                      stop_nxt  = a_dec;
                      phase_nxt = PH_RA_FILL;
                    end
                    default: begin
                      if (cursor_r != a_dec) begin
                        stop_nxt  = a_dec;
                        back_nxt  = cursor_r;
                        inf_nxt   = 1'b0;
                        eprot_nxt = 1'b0;
                        act       = ACT_EUA;
                      end
                    end
                  endcase
                end
                PH_RA_FILL: begin
                  phase_nxt = PH_DATA;
                  if (cursor_r != ra_stop) begin
                    stop_nxt = ra_stop;
                    fill_nxt = ebc;
                    act      = ACT_RA;
                  end
                end
                PH_SF: begin
                  phase_nxt = PH_DATA;
                  do_sf     = 1'b1;
                  sf_prot   = b[5];
                end
                PH_SFE_CNT: begin
                  pprot_nxt = 1'b1;
                  if (b == '0) begin
                    phase_nxt = PH_DATA;
                    do_sf     = 1'b1;
                    sf_prot   = 1'b1;
                  end else begin
                    cnt_nxt   = OPCNT_W'(b);
                    phase_nxt = PH_SFE_TYPE;
                  end
                end
                PH_SFE_TYPE: begin
                  phase_nxt = (b == ATTR_FLD) ? PH_SFE_VAL_FLD : PH_SFE_VAL_OTH;
                end
                PH_SFE_VAL_FLD, PH_SFE_VAL_OTH: begin
                  sf_prot = (phase_r == PH_SFE_VAL_FLD) ? b[5] : pprot_r;
                  pprot_nxt = sf_prot;
                  cnt_nxt   = cnt_dec;
                  if (cnt_dec == '0) begin
                    phase_nxt = PH_DATA;
                    do_sf     = 1'b1;
                  end else begin
                    phase_nxt = PH_SFE_TYPE;
                  end
                end
                PH_SKIP: begin
                  cnt_nxt = cnt_dec;
                  if (cnt_dec == '0) phase_nxt = PH_DATA;
                end
                PH_MF_CNT: begin
                  if (b == '0) begin
                    phase_nxt = PH_DATA;
                  end else begin
                    cnt_nxt   = OPCNT_W'({b, 1'b0});
                    phase_nxt = PH_SKIP;
                  end
                end
                default: begin
                  // data phase: orders or a displayable character
                  phase_nxt = PH_DATA;
                  case (b)
                    ORD_SBA: begin
                      kind_nxt  = KIND_SBA;
                      phase_nxt = PH_ADDR_HI;
                    end
                    ORD_RA: begin
                      kind_nxt  = KIND_RA;
                      phase_nxt = PH_ADDR_HI;
                    end
                    ORD_EUA: begin
                      kind_nxt  = KIND_EUA;
                      phase_nxt = PH_ADDR_HI;
                    end
                    ORD_SF:  phase_nxt = PH_SF;
                    ORD_SFE: phase_nxt = PH_SFE_CNT;
                    ORD_SA: begin
                      cnt_nxt   = OPCNT_W'(2);
                      phase_nxt = PH_SKIP;
                    end
                    ORD_MF:  phase_nxt = PH_MF_CNT;
                    ORD_IC:  phase_nxt = PH_DATA;
                    ORD_PT:  act = ACT_FIC;
                    default: do_put = 1'b1;
                  endcase
                end
              endcase
            end

            if (do_sf) begin
              mw_en      = 1'b1;
              mw_data    = '{prot: sf_prot, fs: 1'b1};
              cw_en      = 1'b1;
              anyf_nxt   = 1'b1;
              cursor_nxt = cur_adv;
            end
            if (do_put) begin
              cw_en      = 1'b1;
              cw_data    = ebc;
              cursor_nxt = cur_adv;
            end

            // record end: drop unfinished orders, place cursor if fields exist
            if (active && in_data.last_of_record) begin
              phase_nxt  = PH_IDLE;
              cnt_nxt    = '0;
              ficaft_nxt = 1'b1;
              if (act == ACT_DONE && anyf_nxt) act = ACT_FIC;
            end else begin
              ficaft_nxt = 1'b0;
            end

            if (act == ACT_FIC) begin
              iss_nxt  = '0;
              dv_nxt   = 1'b0;
              pufs_nxt = 1'b0;
            end

            if (act == ACT_DONE && out_free) begin
              out_valid_nxt                    = 1'b1;
              out_data_nxt.cell_char           = '0;
              out_data_nxt.cell_is_field_start = 1'b0;
              out_data_nxt.cell_protected      = 1'b0;
              out_data_nxt.cursor_position     = POS_W'(cursor_nxt);
            end
          end
        end
      end

      ST_READ: begin
        res_char_nxt = rd_char_r;
        res_fs_nxt   = rd_mark_r.fs;
        res_prot_nxt = rd_mark_r.prot;
      end

      ST_FIC: begin
        if (fic_end) begin
          cursor_nxt = fic_hit ? di_r : '0;
        end else begin
          rd_addr = iss_r;
          iss_nxt = iss_r + ADDR_W'(1);
          di_nxt  = iss_r;
          dv_nxt  = 1'b1;
          if (dv_r) pufs_nxt = rd_mark_r.fs && !rd_mark_r.prot;
        end
      end

      ST_RA: begin
        cw_en      = 1'b1;
        cw_data    = fill_r;
        cursor_nxt = cur_adv;
        if (walk_end && fic_go) begin
          iss_nxt  = '0;
          dv_nxt   = 1'b0;
          pufs_nxt = 1'b0;
        end
      end

      ST_EUA_BR: begin
        // walk back to the nearest field start before the cursor
        rd_addr = back_r - ADDR_W'(1);
        if (back_r != '0) back_nxt = back_r - ADDR_W'(1);
      end

      ST_EUA_BE: begin
        if (rd_mark_r.fs) begin
          inf_nxt   = 1'b1;
          eprot_nxt = rd_mark_r.prot;
        end
      end

      ST_EUA_FR: rd_addr = cursor_r;

      ST_EUA_FE: begin
        if (rd_mark_r.fs) begin
          inf_nxt   = 1'b1;
          eprot_nxt = rd_mark_r.prot;
        end else if (inf_r && !eprot_r) begin
          cw_en = 1'b1;
        end
        cursor_nxt = cur_adv;
        if (walk_end && fic_go) begin
          iss_nxt  = '0;
          dv_nxt   = 1'b0;
          pufs_nxt = 1'b0;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt                    = 1'b1;
          out_data_nxt.cell_char           = res_char_r;
          out_data_nxt.cell_is_field_start = res_fs_r;
          out_data_nxt.cell_protected      = res_prot_r;
          out_data_nxt.cursor_position     = POS_W'(cursor_r);
        end
      end

      default: ;
    endcase

    // the user must write geometry only while idle; the block itself does not enforce it
    if (cfg_we) begin
      rows_nxt = rows_new;
      cols_nxt = cols_new;
      n_nxt    = cells_new;
      if (CNT_W'(cursor_r) >= cells_new) cursor_nxt = '0;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (clr_last) st_nxt = clr_item_r ? ST_EMIT : ST_IDLE;
      ST_IDLE: begin
        case (act)
          ACT_READ:  st_nxt = ST_READ;
          ACT_FIC:   st_nxt = ST_FIC;
          ACT_RA:    st_nxt = ST_RA;
          ACT_EUA:   st_nxt = ST_EUA_BR;
          ACT_CLEAR: st_nxt = ST_CLEAR;
          ACT_DONE:  st_nxt = out_free ? ST_IDLE : ST_EMIT;
          default:   st_nxt = ST_IDLE;
        endcase
      end
      ST_READ:   st_nxt = ST_EMIT;
      ST_FIC:    if (fic_end) st_nxt = ST_EMIT;
      ST_RA:     if (walk_end) st_nxt = fic_go ? ST_FIC : ST_EMIT;
      ST_EUA_BR: st_nxt = (back_r == '0) ? ST_EUA_FR : ST_EUA_BE;
      ST_EUA_BE: st_nxt = rd_mark_r.fs ? ST_EUA_FR : ST_EUA_BR;
      ST_EUA_FR: st_nxt = ST_EUA_FE;
      ST_EUA_FE: begin
        if (walk_end) st_nxt = fic_go ? ST_FIC : ST_EMIT;
        else          st_nxt = ST_EUA_FR;
      end
      ST_EMIT:   if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      phase_r     <= PH_IDLE;
      kind_r      <= KIND_SBA;
      cursor_r    <= '0;
      rows_r      <= ROWS_RST;
      cols_r      <= COLS_RST;
      n_r         <= cell_count(ROWS_RST, COLS_RST);
      cnt_r       <= '0;
      paddr_r     <= '0;
      pprot_r     <= 1'b1;
      anyf_r      <= 1'b0;
      stop_r      <= '0;
      ficaft_r    <= 1'b0;
      inf_r       <= 1'b0;
      eprot_r     <= 1'b0;
      back_r      <= '0;
      iss_r       <= '0;
      di_r        <= '0;
      dv_r        <= 1'b0;
      pufs_r      <= 1'b0;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      cursor_r    <= cursor_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      paddr_r     <= paddr_nxt;
      pprot_r     <= pprot_nxt;
      anyf_r      <= anyf_nxt;
      stop_r      <= stop_nxt;
      ficaft_r    <= ficaft_nxt;
      inf_r       <= inf_nxt;
      eprot_r     <= eprot_nxt;
      back_r      <= back_nxt;
      iss_r       <= iss_nxt;
      di_r        <= di_nxt;
      dv_r        <= dv_nxt;
      pufs_r      <= pufs_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fill_r     <= fill_nxt;
    res_char_r <= res_char_nxt;
    res_fs_r   <= res_fs_nxt;
    res_prot_r <= res_prot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/btwop_chk.sv =====
`default_nettype none
`include "block_terminal_write_order_parser_unit_assert.svh"

module btwop_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire btwop_pkg::out_item_t out_data
);
  import btwop_pkg::*;

  // a stalled result stays and holds its payload
  `BTWOP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // protection is only ever recorded together with a field start
  `BTWOP_ASSERT_IMPL(a_prot_fs, clk, rst_n, out_valid && out_data.cell_protected, out_data.cell_is_field_start)

  // after reset the screen sweep holds off requests and no result is shown
  `BTWOP_ASSERT_RST(a_rst_sweep, clk, !rst_n, in_stall && !out_valid)

endmodule

bind block_terminal_write_order_parser_unit btwop_chk u_btwop_chk (.*);

`default_nettype wire

// ===== tb/block_terminal_write_order_parser_unit_tb.sv =====
`timescale 1ns / 100ps

module block_terminal_write_order_parser_unit_tb;
  import btwop_pkg::*;

  localparam int RAND_ITEMS = 700;
  localparam int CYCLE_LIMIT = 60000000;
  localparam int SETTLE = 64;

  // ---------------------------------------------------------------------------
  // clock, reset and the ports of the block
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  block_terminal_write_order_parser_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // screen model: our own copy of the geometry, cells, marks and parse state
  // ---------------------------------------------------------------------------
  logic [ROWS_W-1:0] geo_rows;
  logic [COLS_W-1:0] geo_cols;
  logic [CHAR_W-1:0] scr_char [MAX_CELLS];
  logic [1:0] scr_mark [MAX_CELLS];  // bit0 field start, bit1 protected
  int unsigned cur;
  phase_t phase;
  logic [OPCNT_W-1:0] opnd_count;
  int unsigned pend_addr;
  logic pend_prot;
  logic fields_seen;

  out_item_t result_q[$];  // expected results, oldest first
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned reqs_sent = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;  // no idling on either side

  // pinned expectation for directed rows that are read off at a glance
  logic pin_valid = 1'b0;
  out_item_t pin_result = '0;

  function automatic int unsigned screen_cells();
    int unsigned r, c, p;
    r = (geo_rows == 0) ? 1 : geo_rows;
    c = (geo_cols == 0) ? 1 : geo_cols;
    p = r * c;
    return (p > MAX_CELLS) ? MAX_CELLS : p;
  endfunction

  function automatic void wipe_screen();
    for (int i = 0; i < MAX_CELLS; i++) begin
      scr_char[i] = CHAR_SPACE;
      scr_mark[i] = 2'b00;
    end
  endfunction

  function automatic void model_reset();
    geo_rows = ROWS_RST;
    geo_cols = COLS_RST;
    wipe_screen();
    cur = 0;
    phase = PH_IDLE;
    opnd_count = '0;
    pend_addr = 0;
    pend_prot = 1'b1;
    fields_seen = 1'b0;
  endfunction

  function automatic void model_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == REG_ROWS) geo_rows = val[ROWS_W-1:0];
    else geo_cols = val[COLS_W-1:0];
    // geometry shrink pushes a stranded cursor home
    if (cur >= screen_cells()) cur = 0;
  endfunction

  // ebcdic to ascii, written out by range and by symbol
  function automatic logic [CHAR_W-1:0] to_ascii(logic [7:0] c);
    int v;
    v = c;
    if (v >= 'hF0 && v <= 'hF9) return CHAR_W'("0" + v - 'hF0);
    if (v >= 'hC1 && v <= 'hC9) return CHAR_W'("A" + v - 'hC1);
    if (v >= 'hD1 && v <= 'hD9) return CHAR_W'("J" + v - 'hD1);
    if (v >= 'hE2 && v <= 'hE9) return CHAR_W'("S" + v - 'hE2);
    if (v >= 'h81 && v <= 'h89) return CHAR_W'("a" + v - 'h81);
    if (v >= 'h91 && v <= 'h99) return CHAR_W'("j" + v - 'h91);
    if (v >= 'hA2 && v <= 'hA9) return CHAR_W'("s" + v - 'hA2);
    case (c)
      8'h4B: return ".";
      8'h6B: return ",";
      8'h5A: return "!";
      8'h6E: return ">";
      8'h4C: return "<";
      8'h5B: return "$";
      8'h7B: return "#";
      8'h7E: return "=";
      8'h60: return "-";
      8'h61: return "/";
      8'h6C: return "%";
      8'h7C: return "@";
      8'h4D: return "(";
      8'h5D: return ")";
      8'h50: return "&";
      8'h7A: return ":";
      8'h5E: return ";";
      8'h6D: return "_";
      8'h7D: return "'";
      8'h7F: return "\"";
      8'h4E: return "+";
      8'h5C: return "*";
      8'h4F: return "|";
      8'h6F: return "?";
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic void bump_cursor(int unsigned n);
    cur = (cur + 1) % n;
  endfunction

  function automatic void open_field(logic prot, int unsigned n);
    scr_mark[cur] = {prot, 1'b1};
    scr_char[cur] = CHAR_SPACE;
    fields_seen = 1'b1;
    bump_cursor(n);
  endfunction

  // cell after the lowest unprotected field start with a usable next cell
  function automatic int unsigned first_input(int unsigned n);
    for (int unsigned s = 0; s < n; s++) begin
      if (scr_mark[s] == 2'b01 && s + 1 < n && !scr_mark[s+1][0]) return s + 1;
    end
    return 0;
  endfunction

  function automatic void erase_open_cells(int unsigned stop, int unsigned n);
    bit in_fld, prot;
    int unsigned c;
    in_fld = 0;
    prot = 0;
    c = cur;
    // find the field the cursor sits in
    while (c > 0) begin
      c--;
      if (scr_mark[c][0]) begin
        in_fld = 1;
        prot = scr_mark[c][1];
        break;
      end
    end
    while (cur != stop) begin
      if (scr_mark[cur][0]) begin
        in_fld = 1;
        prot = scr_mark[cur][1];
      end else if (in_fld && !prot) begin
        scr_char[cur] = CHAR_SPACE;
      end
      bump_cursor(n);
      if (cur == 0) break;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, int unsigned n);
    int unsigned a;
    case (phase)
      PH_WCC: phase = PH_DATA;
      PH_ADDR_HI: begin
        pend_addr = b[5:0];
        phase = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        a = (pend_addr << 6) | b[5:0];
        if (a >= n) a = n - 1;
        phase = PH_DATA;
        if (opnd_count == OPCNT_W'(KIND_SBA)) begin
          cur = a;
        end else if (opnd_count == OPCNT_W'(KIND_RA)) begin
          pend_addr = a;
          phase = PH_RA_FILL;
        end else begin
          erase_open_cells(a, n);
        end
      end
      PH_RA_FILL: begin
        phase = PH_DATA;
        if (pend_addr >= n) pend_addr = n - 1;
        while (cur != pend_addr) begin
          scr_char[cur] = to_ascii(b);
          bump_cursor(n);
          if (cur == 0) break;
        end
      end
      PH_SF: begin
        phase = PH_DATA;
        open_field(b[5], n);
      end
      PH_SFE_CNT: begin
        pend_prot = 1'b1;
        if (b == 0) begin
          phase = PH_DATA;
          open_field(1'b1, n);
        end else begin
          opnd_count = OPCNT_W'(b);
          phase = PH_SFE_TYPE;
        end
      end
      PH_SFE_TYPE: phase = (b == ATTR_FLD) ? PH_SFE_VAL_FLD : PH_SFE_VAL_OTH;
      PH_SFE_VAL_FLD, PH_SFE_VAL_OTH: begin
        if (phase == PH_SFE_VAL_FLD) pend_prot = b[5];
        opnd_count = opnd_count - 1'b1;
        if (opnd_count == 0) begin
          phase = PH_DATA;
          open_field(pend_prot, n);
        end else begin
          phase = PH_SFE_TYPE;
        end
      end
      PH_SKIP: begin
        opnd_count = opnd_count - 1'b1;
        if (opnd_count == 0) phase = PH_DATA;
      end
      PH_MF_CNT: begin
        if (b == 0) begin
          phase = PH_DATA;
        end else begin
          opnd_count = OPCNT_W'({b, 1'b0});
          phase = PH_SKIP;
        end
      end
      default: begin
        phase = PH_DATA;
        case (b)
          ORD_SBA: begin
            opnd_count = OPCNT_W'(KIND_SBA);
            phase = PH_ADDR_HI;
          end
          ORD_RA: begin
            opnd_count = OPCNT_W'(KIND_RA);
            phase = PH_ADDR_HI;
          end
          ORD_EUA: begin
            opnd_count = OPCNT_W'(KIND_EUA);
            phase = PH_ADDR_HI;
          end
          ORD_SF: phase = PH_SF;
          ORD_SFE: phase = PH_SFE_CNT;
          ORD_SA: begin
            opnd_count = 2;
            phase = PH_SKIP;
          end
          ORD_MF: phase = PH_MF_CNT;
          ORD_IC: ;
          ORD_PT: cur = first_input(n);
          default: begin
            scr_char[cur] = to_ascii(b);
            bump_cursor(n);
          end
        endcase
      end
    endcase
  endfunction

  // one request in, the expected result out
  function automatic out_item_t predict_screen(in_item_t r);
    out_item_t o;
    int unsigned n, a;
    bit active;
    n = screen_cells();
    o = '0;
    if (r.op) begin
      a = r.read_address;
      if (a >= n) a = n - 1;
      o.cell_char = scr_char[a];
      o.cell_is_field_start = scr_mark[a][0];
      o.cell_protected = scr_mark[a][1];
    end else begin
      active = r.first_of_record || phase != PH_IDLE;
      if (r.first_of_record) begin
        if (r.data_byte == CMD_EW || r.data_byte == CMD_EWA) begin
          wipe_screen();
          cur = 0;
          fields_seen = 1'b0;
        end
        phase = (r.data_byte == CMD_W || r.data_byte == CMD_EW || r.data_byte == CMD_EWA)
                ? PH_WCC : PH_DATA;
        opnd_count = '0;
      end else if (active) begin
        parse_byte(r.data_byte, n);
      end
      // record end: park the cursor at the first input cell if fields were seen
      if (active && r.last_of_record) begin
        if (fields_seen) cur = first_input(n);
        phase = PH_IDLE;
        opnd_count = '0;
      end
    end
    o.cursor_position = POS_W'(cur);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // checking: predict on each accepted request, compare each accepted result
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t calc;
    if (rst_n) begin
      cycles++;
      if (in_valid && !in_stall) begin
        calc = predict_screen(in_data);
        result_q.push_back(pin_valid ? pin_result : calc);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", out_data, 0);
        end else begin
          want = result_q.pop_front();
          if (out_data.cell_char !== want.cell_char)
            report_mismatch("cell_char", out_data.cell_char, want.cell_char);
          if (out_data.cell_is_field_start !== want.cell_is_field_start)
            report_mismatch("cell_is_field_start", out_data.cell_is_field_start,
                            want.cell_is_field_start);
          if (out_data.cell_protected !== want.cell_protected)
            report_mismatch("cell_protected", out_data.cell_protected, want.cell_protected);
          if (out_data.cursor_position !== want.cursor_position)
            report_mismatch("cursor_position", out_data.cursor_position,
                            want.cursor_position);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, result_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure: random bursts of stalled cycles
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 11) == 0) stall_left <= $urandom_range(1, 18);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // present one request, optionally after a gap, and hold it until accepted
  task automatic send_req(in_item_t r, bit pinned, out_item_t pinv);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    pin_valid <= pinned;
    pin_result <= pinv;
    do @(posedge clk); while (in_stall);
    reqs_sent++;
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    pin_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_geometry(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    model_cfg(REG_ROWS, rows);
    cfg_index <= REG_COLS;
    cfg_data <= cols;
    @(posedge clk);
    model_cfg(REG_COLS, cols);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t rec_byte(logic [7:0] b, bit first, bit last);
    in_item_t r;
    r = '0;
    r.data_byte = b;
    r.first_of_record = first;
    r.last_of_record = last;
    r.read_address = POS_W'($urandom);  // ignored on stream bytes
    return r;
  endfunction

  function automatic in_item_t cell_read(int unsigned addr);
    in_item_t r;
    r = '0;
    r.op = 1'b1;
    r.read_address = POS_W'(addr);
    r.data_byte = 8'($urandom);  // ignored on reads
    r.first_of_record = 1'($urandom);
    r.last_of_record = 1'($urandom);
    return r;
  endfunction

  // body of a random record: orders with random operands and text
  logic [7:0] body_q[$];

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range('hC1, 'hC9));
      1: return 8'($urandom_range('hF0, 'hF9));
      2: return 8'h4B;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_addr();
    body_q.push_back(8'($urandom));
    body_q.push_back(8'($urandom));
  endfunction

  function automatic void add_order();
    int unsigned pairs;
    case ($urandom_range(0, 15))
      0, 1: begin
        body_q.push_back(ORD_SBA);
        add_addr();
      end
      2, 3: begin
        body_q.push_back(ORD_SF);
        body_q.push_back(8'($urandom));
      end
      4: begin
        body_q.push_back(ORD_SFE);
        pairs = $urandom_range(0, 3);
        body_q.push_back(8'(pairs));
        for (int i = 0; i < pairs; i++) begin
          body_q.push_back($urandom_range(0, 1) ? ATTR_FLD : 8'($urandom));
          body_q.push_back(8'($urandom));
        end
      end
      5: begin
        body_q.push_back(ORD_SA);
        body_q.push_back(8'($urandom));
        body_q.push_back(8'($urandom));
      end
      6: begin
        body_q.push_back(ORD_MF);
        pairs = $urandom_range(0, 2);
        body_q.push_back(8'(pairs));
        for (int i = 0; i < 2 * pairs; i++) body_q.push_back(8'($urandom));
      end
      7: body_q.push_back(ORD_IC);
      8: body_q.push_back(ORD_PT);
      9: begin
        body_q.push_back(ORD_RA);
        add_addr();
        body_q.push_back(text_byte());
      end
      10: begin
        body_q.push_back(ORD_EUA);
        add_addr();
      end
      default: repeat ($urandom_range(1, 6)) body_q.push_back(text_byte());
    endcase
  endfunction

  // a whole record; now and then cut short, with cell reads mixed in
  task automatic send_record(int unsigned n);
    logic [7:0] cmd;
    int unsigned k, len;
    out_item_t none;
    none = '0;
    body_q.delete();
    case ($urandom_range(0, 9))
      0: cmd = CMD_EW;
      1: cmd = CMD_EWA;
      2, 3, 4, 5: cmd = CMD_W;
      default: cmd = 8'($urandom);
    endcase
    if (cmd == CMD_W || cmd == CMD_EW || cmd == CMD_EWA) body_q.push_back(8'($urandom));
    repeat ($urandom_range(1, 8)) add_order();
    len = body_q.size();
    if ($urandom_range(0, 7) == 0) len = $urandom_range(0, len);  // truncated record
    send_req(rec_byte(cmd, 1'b1, len == 0), 0, none);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_req(cell_read($urandom_range(0, n - 1)), 0, none);
      send_req(rec_byte(body_q[k], 1'b0, k == len - 1), 0, none);
    end
    // a few reads to look at what was written
    repeat ($urandom_range(0, 3)) begin
      k = ($urandom_range(0, 15) == 0) ? $urandom_range(0, MAX_CELLS - 1)
                                       : $urandom_range(0, n - 1);
      send_req(cell_read(k), 0, none);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed rows: fresh-screen reads, the erase and its wcc byte pinned, the rest predicted
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t req;
    bit pinned;
    out_item_t res;
  } row_t;

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    row_t rows[$];
    row_t rw;
    out_item_t blank;
    int unsigned target;
    logic [CFG_W-1:0] geo_r [6];
    logic [CFG_W-1:0] geo_c [6];

    model_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fresh screen: spaces, no marks, cursor home
    blank = '0;
    blank.cell_char = CHAR_SPACE;
    rw.pinned = 1; rw.res = blank;
    rw.req = cell_read(0); rows.push_back(rw);
    rw.req = cell_read(MAX_CELLS - 1); rows.push_back(rw);  // clamps to the last cell
    rw.res = '0;
    rw.req = rec_byte(CMD_EW, 1, 0); rows.push_back(rw);  // erase, cursor 0
    rw.req = rec_byte(8'hC3, 0, 0); rows.push_back(rw);   // wcc skipped
    rw.pinned = 0;
    begin
      logic [7:0] seq[$];
      // SBA 5, char, SF unprotected, SFE protected, RA, MF, PT, EUA to end, IC
      seq = '{ORD_SBA, 8'h00, 8'h05, 8'hC1, ORD_SF, 8'h00,
              ORD_SFE, 8'h01, ATTR_FLD, 8'h20, ORD_RA, 8'h00, 8'h14, 8'hF1,
              ORD_MF, 8'h01, 8'h41, 8'hF2, ORD_PT, ORD_EUA, 8'hFF, 8'hFF, ORD_IC};
      foreach (seq[i]) begin
        rw.req = rec_byte(seq[i], 0, 0);
        rows.push_back(rw);
      end
    end
    rw.req = rec_byte(ORD_SBA, 0, 1); rows.push_back(rw);  // order cut off by record end
    rw.req = rec_byte(8'hFF, 0, 1); rows.push_back(rw);    // stray byte outside a record
    rw.req = cell_read(7); rows.push_back(rw);
    foreach (rows[i]) send_req(rows[i].req, rows[i].pinned, rows[i].res);

    // geometry phases: reset size, extremes, zero (used as one), odd shapes
    geo_r = '{8'd24, 8'd1, 8'hFF, 8'd0, 8'd5, 8'd64};
    geo_c = '{8'd80, 8'd1, 8'hFF, 8'd0, 8'd7, 8'd128};
    for (int p = 0; p < 6; p++) begin
      write_geometry(geo_r[p], geo_c[p]);
      quiet = (p == 5);
      target = reqs_sent + RAND_ITEMS / 6;
      while (reqs_sent < target) begin
        send_record(screen_cells());
        // near the end of the third geometry the sender holds off until everything is back
        if (p == 2 && reqs_sent > target - RAND_ITEMS / 12 && result_q.size() != 0) begin
          in_valid <= 1'b0;
          pin_valid <= 1'b0;
          while (result_q.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    $display("covered %0d requests over six screen geometries, %0d results compared",
             reqs_sent, results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches found", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
